/* rtl/c8eu_pkg.sv */
// ----------------------------------------------------------------------------
// c8eu_pkg
// Shared types and constants for the 8-bit execute unit: decoded operation
// classes, branch flag selects, the decode control group and the result item.
// ----------------------------------------------------------------------------
package c8eu_pkg;

  // operation classes after decode
  typedef enum logic [5:0] {
    OP_LDA, OP_LDX, OP_LDY,
    OP_STA, OP_STX, OP_STY,
    OP_ADC, OP_SBC,
    OP_AND, OP_EOR, OP_ORA,
    OP_CMP, OP_CPX, OP_CPY,
    OP_SHIFT_ACC, OP_SHIFT_MEM,
    OP_BRANCH,
    OP_INC, OP_DEC,
    OP_INX, OP_INY, OP_DEX, OP_DEY,
    OP_BIT,
    OP_SEC, OP_SED, OP_SEI, OP_CLC, OP_CLD, OP_CLI, OP_CLV,
    OP_TAX, OP_TAY, OP_TXA, OP_TYA, OP_TSX, OP_TXS,
    OP_NOP,
    OP_UNKNOWN
  } op_t;

  // flag tested by a conditional branch, from opcode bits 7:6
  typedef enum logic [1:0] {
    BR_FLAG_N = 2'd0,
    BR_FLAG_V = 2'd1,
    BR_FLAG_C = 2'd2,
    BR_FLAG_Z = 2'd3
  } br_flag_t;

  typedef struct packed {
    op_t      op;
    logic     sh_right;   // shift/rotate toward bit 0
    logic     sh_rot;     // rotate through carry
    br_flag_t br_sel;
    logic     br_want;    // branch when the flag equals this
  } ctl_t;

  typedef struct packed {
    logic [7:0]  store_data;
    logic        store_enable;
    logic [15:0] new_pc;
    logic        branch_taken;
    logic [7:0]  status_byte;
    logic [7:0]  acc_value;
    logic        unknown_op;
  } res_t;

  localparam logic [7:0] SP_RESET    = 8'hFF;
  localparam logic [4:0] BCD_NIB_MAX = 5'd9;
  localparam logic [9:0] BCD_LO_ADJ  = 10'h006;
  localparam logic [9:0] BCD_LIMIT   = 10'h099;
  localparam logic [9:0] BCD_HI_ADJ  = 10'h060;

endpackage

/* rtl/c8eu_decode.sv */
// ----------------------------------------------------------------------------
// c8eu_decode
// Opcode decode: maps the opcode byte onto an operation class plus the
// shift and branch selects taken from the opcode bits.
// ----------------------------------------------------------------------------
module c8eu_decode (
  input  logic [7:0]    req_type,
  output c8eu_pkg::ctl_t ctl
);

  always_comb begin
    ctl.sh_right = req_type[6];
    ctl.sh_rot   = req_type[5];
    ctl.br_sel   = c8eu_pkg::br_flag_t'(req_type[7:6]);
    ctl.br_want  = req_type[5];
    case (req_type)
      8'hA9, 8'hA5, 8'hB5, 8'hAD, 8'hBD, 8'hB9, 8'hA1, 8'hB1: ctl.op = c8eu_pkg::OP_LDA;
      8'hA2, 8'hA6, 8'hB6, 8'hAE, 8'hBE:                      ctl.op = c8eu_pkg::OP_LDX;
      8'hA0, 8'hA4, 8'hB4, 8'hAC, 8'hBC:                      ctl.op = c8eu_pkg::OP_LDY;
      8'h85, 8'h95, 8'h8D, 8'h9D, 8'h99, 8'h81, 8'h91:        ctl.op = c8eu_pkg::OP_STA;
      8'h86, 8'h96, 8'h8E:                                    ctl.op = c8eu_pkg::OP_STX;
      8'h84, 8'h94, 8'h8C:                                    ctl.op = c8eu_pkg::OP_STY;
      8'h69, 8'h65, 8'h75, 8'h6D, 8'h7D, 8'h79, 8'h61, 8'h71: ctl.op = c8eu_pkg::OP_ADC;
      8'hE9, 8'hE5, 8'hF5, 8'hED, 8'hFD, 8'hF9, 8'hE1, 8'hF1: ctl.op = c8eu_pkg::OP_SBC;
      8'h29, 8'h25, 8'h35, 8'h2D, 8'h3D, 8'h39, 8'h21, 8'h31: ctl.op = c8eu_pkg::OP_AND;
      8'h49, 8'h45, 8'h55, 8'h4D, 8'h5D, 8'h59, 8'h41, 8'h51: ctl.op = c8eu_pkg::OP_EOR;
      8'h09, 8'h05, 8'h15, 8'h0D, 8'h1D, 8'h19, 8'h01, 8'h11: ctl.op = c8eu_pkg::OP_ORA;
      8'hC9, 8'hC5, 8'hD5, 8'hCD, 8'hDD, 8'hD9, 8'hC1, 8'hD1: ctl.op = c8eu_pkg::OP_CMP;
      8'hE0, 8'hE4, 8'hEC:                                    ctl.op = c8eu_pkg::OP_CPX;
      8'hC0, 8'hC4, 8'hCC:                                    ctl.op = c8eu_pkg::OP_CPY;
      8'h0A, 8'h4A, 8'h2A, 8'h6A:                             ctl.op = c8eu_pkg::OP_SHIFT_ACC;
      8'h06, 8'h16, 8'h0E, 8'h1E, 8'h46, 8'h56, 8'h4E, 8'h5E,
      8'h26, 8'h36, 8'h2E, 8'h3E, 8'h66, 8'h76, 8'h6E, 8'h7E: ctl.op = c8eu_pkg::OP_SHIFT_MEM;
      8'h10, 8'h30, 8'h50, 8'h70, 8'h90, 8'hB0, 8'hD0, 8'hF0: ctl.op = c8eu_pkg::OP_BRANCH;
      8'hE6, 8'hF6, 8'hEE, 8'hFE:                             ctl.op = c8eu_pkg::OP_INC;
      8'hC6, 8'hD6, 8'hCE, 8'hDE:                             ctl.op = c8eu_pkg::OP_DEC;
      8'hE8: ctl.op = c8eu_pkg::OP_INX;
      8'hC8: ctl.op = c8eu_pkg::OP_INY;
      8'hCA: ctl.op = c8eu_pkg::OP_DEX;
      8'h88: ctl.op = c8eu_pkg::OP_DEY;
      8'h24, 8'h2C: ctl.op = c8eu_pkg::OP_BIT;
      8'h38: ctl.op = c8eu_pkg::OP_SEC;
      8'hF8: ctl.op = c8eu_pkg::OP_SED;
      8'h78: ctl.op = c8eu_pkg::OP_SEI;
      8'h18: ctl.op = c8eu_pkg::OP_CLC;
      8'hD8: ctl.op = c8eu_pkg::OP_CLD;
      8'h58: ctl.op = c8eu_pkg::OP_CLI;
      8'hB8: ctl.op = c8eu_pkg::OP_CLV;
      8'hAA: ctl.op = c8eu_pkg::OP_TAX;
      8'hA8: ctl.op = c8eu_pkg::OP_TAY;
      8'h8A: ctl.op = c8eu_pkg::OP_TXA;
      8'h98: ctl.op = c8eu_pkg::OP_TYA;
      8'hBA: ctl.op = c8eu_pkg::OP_TSX;
      8'h9A: ctl.op = c8eu_pkg::OP_TXS;
      8'hEA: ctl.op = c8eu_pkg::OP_NOP;
      default: ctl.op = c8eu_pkg::OP_UNKNOWN;
    endcase
  end

endmodule

/* rtl/c8eu_exec.sv */
// ----------------------------------------------------------------------------
// c8eu_exec
// Register file (A, X, Y, SP, flags) and the combinational datapath: adder
// with decimal adjust, logic ops, compare, shifter and branch target add.
// ----------------------------------------------------------------------------
module c8eu_exec (
  input  logic           clk,
  input  logic           rst,
  input  logic           exec_en,
  input  c8eu_pkg::ctl_t ctl,
  input  logic [7:0]     operand,
  input  logic [15:0]    next_pc,
  output c8eu_pkg::res_t res
);

  logic [7:0] acc, index_x, index_y, stack_ptr;
  logic       fc, fz, fi, fd, fv, fn;

  logic [7:0] acc_next, index_x_next, index_y_next, stack_ptr_next;
  logic       fc_next, fz_next, fi_next, fd_next, fv_next, fn_next;

  logic [9:0] adc_bin, adc_r1, adc_r;
  logic [4:0] adc_lo;
  logic       adc_v;
  logic [9:0] sbc_bin, sbc_r1, sbc_r;
  logic       sbc_v, sbc_borrow;
  logic [7:0] cmp_reg;
  logic [8:0] cmp_diff;
  logic [7:0] sh_src, sh_res;
  logic       sh_c;
  logic       br_flag;
  logic [15:0] br_target;
  logic [7:0] nz_val;
  logic       nz_upd;

  // add with carry, decimal adjust when D is set
  always_comb begin
    adc_bin = {2'b00, acc} + {2'b00, operand} + {9'd0, fc};
    adc_lo  = {1'b0, acc[3:0]} + {1'b0, operand[3:0]} + {4'd0, fc};
    adc_r1  = adc_bin + ((fd && (adc_lo > c8eu_pkg::BCD_NIB_MAX)) ? c8eu_pkg::BCD_LO_ADJ : 10'd0);
    adc_r   = adc_r1 + ((fd && (adc_r1 > c8eu_pkg::BCD_LIMIT)) ? c8eu_pkg::BCD_HI_ADJ : 10'd0);
    adc_v   = ~(acc[7] ^ operand[7]) & (acc[7] ^ adc_r[7]);
  end

  // subtract as A + ~M + C; carry and overflow from the binary sum, 10-bit wrap
  // keeps the "above 0x99" test right after a low-nibble borrow goes negative
  always_comb begin
    sbc_bin    = {2'b00, acc} + {2'b00, ~operand} + {9'd0, fc};
    sbc_v      = ~(acc[7] ^ ~operand[7]) & (acc[7] ^ sbc_bin[7]);
    sbc_borrow = ({1'b0, acc[3:0]} + {4'd0, fc}) < ({1'b0, operand[3:0]} + 5'd1);
    sbc_r1     = sbc_bin - ((fd && sbc_borrow) ? c8eu_pkg::BCD_LO_ADJ : 10'd0);
    sbc_r      = sbc_r1 - ((fd && (sbc_r1 > c8eu_pkg::BCD_LIMIT)) ? c8eu_pkg::BCD_HI_ADJ : 10'd0);
  end

  // compare, shifter, branch
  always_comb begin
    case (ctl.op)
      c8eu_pkg::OP_CPX: cmp_reg = index_x;
      c8eu_pkg::OP_CPY: cmp_reg = index_y;
      default:          cmp_reg = acc;
    endcase
    cmp_diff = {1'b0, cmp_reg} - {1'b0, operand};

    sh_src = (ctl.op == c8eu_pkg::OP_SHIFT_ACC) ? acc : operand;
    if (ctl.sh_right) begin
      sh_c   = sh_src[0];
      sh_res = {ctl.sh_rot & fc, sh_src[7:1]};
    end else begin
      sh_c   = sh_src[7];
      sh_res = {sh_src[6:0], ctl.sh_rot & fc};
    end

    case (ctl.br_sel)
      c8eu_pkg::BR_FLAG_N: br_flag = fn;
      c8eu_pkg::BR_FLAG_V: br_flag = fv;
      c8eu_pkg::BR_FLAG_C: br_flag = fc;
      c8eu_pkg::BR_FLAG_Z: br_flag = fz;
      default:             br_flag = fz;
    endcase
    br_target = next_pc + {{8{operand[7]}}, operand};
  end

  always_comb begin
    acc_next       = acc;
    index_x_next   = index_x;
    index_y_next   = index_y;
    stack_ptr_next = stack_ptr;
    fc_next = fc;
    fz_next = fz;
    fi_next = fi;
    fd_next = fd;
    fv_next = fv;
    fn_next = fn;
    nz_val  = 8'd0;
    nz_upd  = 1'b0;
    res.store_data   = 8'd0;
    res.store_enable = 1'b0;
    res.new_pc       = next_pc;
    res.branch_taken = 1'b0;
    res.unknown_op   = 1'b0;

    case (ctl.op)
      c8eu_pkg::OP_LDA: begin
        acc_next = operand; nz_val = operand; nz_upd = 1'b1;
      end
      c8eu_pkg::OP_LDX: begin
        index_x_next = operand; nz_val = operand; nz_upd = 1'b1;
      end
      c8eu_pkg::OP_LDY: begin
        index_y_next = operand; nz_val = operand; nz_upd = 1'b1;
      end
      c8eu_pkg::OP_STA: begin
        res.store_data = acc; res.store_enable = 1'b1;
      end
      c8eu_pkg::OP_STX: begin
        res.store_data = index_x; res.store_enable = 1'b1;
      end
      c8eu_pkg::OP_STY: begin
        res.store_data = index_y; res.store_enable = 1'b1;
      end
      c8eu_pkg::OP_ADC: begin
        acc_next = adc_r[7:0];
        fc_next  = adc_r[9] | adc_r[8];
        fv_next  = adc_v;
        nz_val   = adc_r[7:0]; nz_upd = 1'b1;
      end
      c8eu_pkg::OP_SBC: begin
        acc_next = sbc_r[7:0];
        fc_next  = sbc_bin[8];
        fv_next  = sbc_v;
        nz_val   = sbc_r[7:0]; nz_upd = 1'b1;
      end
      c8eu_pkg::OP_AND: begin
        acc_next = acc & operand; nz_val = acc & operand; nz_upd = 1'b1;
      end
      c8eu_pkg::OP_EOR: begin
        acc_next = acc ^ operand; nz_val = acc ^ operand; nz_upd = 1'b1;
      end
      c8eu_pkg::OP_ORA: begin
        acc_next = acc | operand; nz_val = acc | operand; nz_upd = 1'b1;
      end
      c8eu_pkg::OP_CMP, c8eu_pkg::OP_CPX, c8eu_pkg::OP_CPY: begin
        fc_next = ~cmp_diff[8];
        fz_next = (cmp_reg == operand);
        fn_next = cmp_diff[7];
      end
      c8eu_pkg::OP_SHIFT_ACC: begin
        acc_next = sh_res; fc_next = sh_c; nz_val = sh_res; nz_upd = 1'b1;
      end
      c8eu_pkg::OP_SHIFT_MEM: begin
        res.store_data = sh_res; res.store_enable = 1'b1;
        fc_next = sh_c; nz_val = sh_res; nz_upd = 1'b1;
      end
      c8eu_pkg::OP_BRANCH: begin
        if (br_flag == ctl.br_want) begin
          res.new_pc = br_target; res.branch_taken = 1'b1;
        end
      end
      c8eu_pkg::OP_INC: begin
        res.store_data = operand + 8'd1; res.store_enable = 1'b1;
        nz_val = operand + 8'd1; nz_upd = 1'b1;
      end
      c8eu_pkg::OP_DEC: begin
        res.store_data = operand - 8'd1; res.store_enable = 1'b1;
        nz_val = operand - 8'd1; nz_upd = 1'b1;
      end
      c8eu_pkg::OP_INX: begin
        index_x_next = index_x + 8'd1; nz_val = index_x + 8'd1; nz_upd = 1'b1;
      end
      c8eu_pkg::OP_INY: begin
        index_y_next = index_y + 8'd1; nz_val = index_y + 8'd1; nz_upd = 1'b1;
      end
      c8eu_pkg::OP_DEX: begin
        index_x_next = index_x - 8'd1; nz_val = index_x - 8'd1; nz_upd = 1'b1;
      end
      c8eu_pkg::OP_DEY: begin
        index_y_next = index_y - 8'd1; nz_val = index_y - 8'd1; nz_upd = 1'b1;
      end
      c8eu_pkg::OP_BIT: begin
        fz_next = ((acc & operand) == 8'd0);
        fn_next = operand[7];
        fv_next = operand[6];
      end
      c8eu_pkg::OP_SEC: fc_next = 1'b1;
      c8eu_pkg::OP_SED: fd_next = 1'b1;
      c8eu_pkg::OP_SEI: fi_next = 1'b1;
      c8eu_pkg::OP_CLC: fc_next = 1'b0;
      c8eu_pkg::OP_CLD: fd_next = 1'b0;
      c8eu_pkg::OP_CLI: fi_next = 1'b0;
      c8eu_pkg::OP_CLV: fv_next = 1'b0;
      c8eu_pkg::OP_TAX: begin
        index_x_next = acc; nz_val = acc; nz_upd = 1'b1;
      end
      c8eu_pkg::OP_TAY: begin
        index_y_next = acc; nz_val = acc; nz_upd = 1'b1;
      end
      c8eu_pkg::OP_TXA: begin
        acc_next = index_x; nz_val = index_x; nz_upd = 1'b1;
      end
      c8eu_pkg::OP_TYA: begin
        acc_next = index_y; nz_val = index_y; nz_upd = 1'b1;
      end
      c8eu_pkg::OP_TSX: begin
        index_x_next = stack_ptr; nz_val = stack_ptr; nz_upd = 1'b1;
      end
      c8eu_pkg::OP_TXS: stack_ptr_next = index_x;
      c8eu_pkg::OP_NOP: ;
      default: res.unknown_op = 1'b1;
    endcase

    if (nz_upd) begin
      fz_next = (nz_val == 8'd0);
      fn_next = nz_val[7];
    end

    res.acc_value   = acc_next;
    res.status_byte = {fn_next, fv_next, 1'b1, 1'b0, fd_next, fi_next, fz_next, fc_next};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc       <= 8'd0;
      index_x   <= 8'd0;
      index_y   <= 8'd0;
      stack_ptr <= c8eu_pkg::SP_RESET;
      fc <= 1'b0;
      fz <= 1'b0;
      fi <= 1'b0;
      fd <= 1'b0;
      fv <= 1'b0;
      fn <= 1'b0;
    end else if (exec_en) begin
      acc       <= acc_next;
      index_x   <= index_x_next;
      index_y   <= index_y_next;
      stack_ptr <= stack_ptr_next;
      fc <= fc_next;
      fz <= fz_next;
      fi <= fi_next;
      fd <= fd_next;
      fv <= fv_next;
      fn <= fn_next;
    end
  end

endmodule

/* rtl/cpu_8bit_execute_unit.sv */
// ----------------------------------------------------------------------------
// cpu_8bit_execute_unit
// Execute stage of an 8-bit core: takes a fetched opcode, operand byte and
// next pc, updates A/X/Y/SP/flags and returns store data, flags, pc.
// ----------------------------------------------------------------------------
//   channel | direction | handshake            | payload
//   in      | into unit | in_valid / in_stall  | req_type, operand, next_pc
//   out     | from unit | out_valid / out_stall| store_data .. unknown_op
//
// one item per cycle while out_stall is low; each item passes the input register,
// then decode and execute into the result register
// the register file updates as an item moves into the result register, so
// the next item sees its effect with no bubble
// out_stall holds the result register and backs up into in_stall the same
// cycle; in_stall is low whenever the input register is empty or moving
// synchronous reset clears valids, A X Y and flags, and sets SP to 0xFF
// ----------------------------------------------------------------------------
module cpu_8bit_execute_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  req_type,
  input  logic [7:0]  operand,
  input  logic [15:0] next_pc,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  store_data,
  output logic        store_enable,
  output logic [15:0] new_pc,
  output logic        branch_taken,
  output logic [7:0]  status_byte,
  output logic [7:0]  acc_value,
  output logic        unknown_op
);

  logic        in_reg_valid;
  logic [7:0]  in_reg_op;
  logic [7:0]  in_reg_operand;
  logic [15:0] in_reg_pc;
  logic        advance;
  logic        exec_en;
  c8eu_pkg::ctl_t ctl;
  c8eu_pkg::res_t res;
  c8eu_pkg::res_t res_reg;

  assign advance  = ~out_valid | ~out_stall;
  assign in_stall = in_reg_valid & ~advance;
  assign exec_en  = in_reg_valid & advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_reg_valid <= 1'b0;
    end else if (!in_stall) begin
      in_reg_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_reg_op      <= req_type;
      in_reg_operand <= operand;
      in_reg_pc      <= next_pc;
    end
  end

  c8eu_decode u_decode (
    .req_type (in_reg_op),
    .ctl      (ctl)
  );

  c8eu_exec u_exec (
    .clk     (clk),
    .rst     (rst),
    .exec_en (exec_en),
    .ctl     (ctl),
    .operand (in_reg_operand),
    .next_pc (in_reg_pc),
    .res     (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= in_reg_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (exec_en) begin
      res_reg <= res;
    end
  end

  assign store_data   = res_reg.store_data;
  assign store_enable = res_reg.store_enable;
  assign new_pc       = res_reg.new_pc;
  assign branch_taken = res_reg.branch_taken;
  assign status_byte  = res_reg.status_byte;
  assign acc_value    = res_reg.acc_value;
  assign unknown_op   = res_reg.unknown_op;

endmodule

/* rtl/c8eu_checker.sv */
// ----------------------------------------------------------------------------
// c8eu_checker
// Port-level checks on the execute unit's result channel, bound to the top.
// ----------------------------------------------------------------------------
module c8eu_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_stall,
  input logic [7:0]  store_data,
  input logic        store_enable,
  input logic [15:0] new_pc,
  input logic        branch_taken,
  input logic [7:0]  status_byte,
  input logic [7:0]  acc_value,
  input logic        unknown_op
);

  // a held result keeps every field
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(store_data) && $stable(store_enable)
      && $stable(new_pc) && $stable(branch_taken) && $stable(status_byte)
      && $stable(acc_value) && $stable(unknown_op))
    else $error("result changed while stalled");

  // nothing comes out the cycle after reset
  a_reset: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid right after reset");

  // an unhandled opcode neither stores nor branches
  a_unknown_quiet: assert property (@(posedge clk) disable iff (rst)
    out_valid && unknown_op |-> !store_enable && store_data == 8'd0 && !branch_taken)
    else $error("unknown opcode produced side effects");

  // a result that does not store leaves no stale store data
  a_store_excl: assert property (@(posedge clk) disable iff (rst)
    out_valid && !store_enable |-> store_data == 8'd0)
    else $error("store data without store enable");

  // packed status has bit 5 set and the break bit clear, and no result both stores and branches
  a_status_fixed: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> status_byte[5] && !status_byte[4] && !(store_enable && branch_taken))
    else $error("bad fixed status bits or store on branch");

endmodule

bind cpu_8bit_execute_unit c8eu_checker u_c8eu_checker (
  .clk          (clk),
  .rst          (rst),
  .out_valid    (out_valid),
  .out_stall    (out_stall),
  .store_data   (store_data),
  .store_enable (store_enable),
  .new_pc       (new_pc),
  .branch_taken (branch_taken),
  .status_byte  (status_byte),
  .acc_value    (acc_value),
  .unknown_op   (unknown_op)
);
